// ===== rtl/peak_normalizer_assert.svh =====
// ----------------------------------------------------------------------------
// Peak normalizer assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef PEAK_NORMALIZER_ASSERT_SVH
`define PEAK_NORMALIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define PN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PN_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PN_ASSERT(label, clk, rst, prop, msg)
`define PN_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/pn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak normalizer package
// Shared types, widths and codes for the peak normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int SMP_W       = 24;
   localparam int GAIN_W      = 48;
   localparam int FRAC_W      = 24;
   localparam int DIV_STEPS   = GAIN_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_MISALIGNED = 3'd1;
   localparam logic [2:0] STATUS_ZERO_GAIN  = 3'd2;
   localparam logic [2:0] STATUS_RANGE      = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW   = 3'd4;

   localparam logic [1:0] CSR_IDX_CHANNELS  = 2'd0;
   localparam logic [1:0] CSR_IDX_TARGET    = 2'd1;
   localparam logic [1:0] CSR_IDX_THRESHOLD = 2'd2;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample_in;
      logic                    last_in;
   } pn_req_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample_out;
      logic [2:0]              status;
      logic                    passthrough;
      logic [SMP_W-1:0]        peak_level;
      logic [GAIN_W-1:0]       applied_gain;
      logic                    last_out;
   } pn_rsp_type;

   typedef struct packed {
      logic               done;
      logic [GAIN_W-1:0]  quotient;
      logic [SMP_W-1:0]   remainder;
   } pn_div_res_type;

   typedef struct packed {
      logic                    done;
      logic                    out_of_range;
      logic signed [SMP_W-1:0] value;
   } pn_scl_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MOD,
      ST_DECIDE,
      ST_DIV,
      ST_READ,
      ST_LAUNCH,
      ST_SCALE,
      ST_FAULT
   } pn_state_type;

endpackage

// ===== rtl/pn_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak normalizer divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "peak_normalizer_assert.svh"
module pn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pn_pkg::GAIN_W-1:0]     dividend,
   input  logic [pn_pkg::SMP_W-1:0]      divisor,
   output pn_pkg::pn_div_res_type        result
);
   import pn_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [GAIN_W-1:0]    dq_ff, dq_in;
   logic [SMP_W-1:0]     rem_ff, rem_in;
   logic [SMP_W-1:0]     dsr_ff, dsr_in;
   logic [SMP_W:0]       trial;
   logic [SMP_W+1:0]     diff;
   logic                 fits;

   assign trial = {rem_ff, dq_ff[GAIN_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};
   assign fits  = !diff[SMP_W+1];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dq_in  = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (run_ff) begin
         dq_in  = {dq_ff[GAIN_W-2:0], fits};
         rem_in = fits ? diff[SMP_W-1:0] : trial[SMP_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = dq_ff;
   assign result.remainder = rem_ff;

   `PN_ASSERT_NEVER(a_div_start_while_run, clock, reset, start && run_ff, "divider restarted")
   `PN_ASSERT(a_div_done_follows_run, clock, reset, done_ff |-> $past(run_ff), "stray done")
   `PN_ASSERT_NEVER(a_div_done_and_run, clock, reset, done_ff && run_ff, "done while running")

endmodule

// ===== rtl/pn_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak normalizer scaler
// Multiplies a sample by a Q24.24 gain in two halves on one multiplier,
// rounds half up to Q1.23 and flags results outside the sample range.
// ----------------------------------------------------------------------------
module pn_scaler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [pn_pkg::SMP_W-1:0]  sample,
   input  logic [pn_pkg::GAIN_W-1:0]        gain,
   output pn_pkg::pn_scl_res_type           result
);
   import pn_pkg::*;

   localparam int PROD_W = SMP_W + FRAC_W + 1;
   localparam int ACC_W  = PROD_W + 1;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [1:0]                ph_ff, ph_in;
   logic signed [SMP_W-1:0]   smp_ff, smp_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [FRAC_W-1:0]         mul_b;

   assign mul_b   = (ph_ff == 2'd0) ? gain_ff[FRAC_W-1:0] : gain_ff[GAIN_W-1:FRAC_W];
   assign prod_in = smp_ff * $signed({1'b0, mul_b});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      ph_in   = ph_ff;
      smp_in  = smp_ff;
      gain_in = gain_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in  = 1'b1;
         ph_in   = 2'd0;
         smp_in  = sample;
         gain_in = gain;
      end else if (run_ff) begin
         ph_in = ph_ff + 2'd1;
         if (ph_ff == 2'd1) begin
            acc_in = {prod_ff[PROD_W-1], prod_ff} + ROUND_BIAS;
         end else if (ph_ff == 2'd2) begin
            acc_in  = acc_ff + {prod_ff[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      ph_ff   <= ph_in;
      smp_ff  <= smp_in;
      gain_ff <= gain_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign result.done         = done_ff;
   assign result.value        = acc_ff[FRAC_W+SMP_W-1:FRAC_W];
   assign result.out_of_range = !((acc_ff[ACC_W-1:FRAC_W+SMP_W-1] == '0) ||
                                  (acc_ff[ACC_W-1:FRAC_W+SMP_W-1] == '1));

endmodule

// ===== rtl/peak_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak normalizer
// Buffers interleaved Q1.23 samples, checks them and emits them scaled by
// target / peak (or unchanged below the silence threshold).
// ----------------------------------------------------------------------------
// Load: one sample per cycle while busy is low; the sample marked last sets busy.
// After last: a channel check by division, then the gain division, then a range
// scan over the samples and a second pass that emits them (a silent buffer goes straight to the emit pass).
// One result per strobe cycle; results cannot be stalled.
// Error buffers give one status result, with last_out set, in place of samples.
// Synchronous active-high reset clears buffer state and loads register defaults.
`include "peak_normalizer_assert.svh"
module peak_normalizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pn_pkg::pn_req_type  req_data,
   output logic                rsp_strobe,
   output pn_pkg::pn_rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import pn_pkg::*;

   pn_state_type             state_ff, state_in;
   logic [4:0]               ch_ff, ch_in;
   logic [SMP_W-1:0]         tgt_ff, tgt_in;
   logic [SMP_W-2:0]         thr_ff, thr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [SMP_W-1:0]         peak_ff, peak_in;
   logic                     ovf_ff, ovf_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     emit_ff, emit_in;
   logic                     pass_ff, pass_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [2:0]               fault_ff, fault_in;
   logic signed [SMP_W-1:0]  rd_ff;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   pn_rsp_type               rsp_data_ff, rsp_data_in;
   logic signed [SMP_W-1:0]  sample_store [MAX_SAMPLES];

   logic                     csr_write;
   logic                     accept;
   logic                     room;
   logic [SMP_W-1:0]         mag;
   logic                     last_idx;
   logic                     silent;
   logic                     div_start;
   logic                     div_gain;
   logic [GAIN_W-1:0]        div_dividend;
   logic [SMP_W-1:0]         div_divisor;
   logic                     scl_start;
   logic                     start_pass;
   logic                     load_gain;
   logic                     scan_end;
   logic                     step_idx;
   logic                     emit_now;
   logic                     fault_now;
   logic                     set_fault;
   logic [2:0]               fault_code;
   logic                     clear;
   pn_div_res_type           div_res;
   pn_scl_res_type           scl_res;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      ch_in  = ch_ff;
      tgt_in = tgt_ff;
      thr_in = thr_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            CSR_IDX_CHANNELS:  ch_in  = pwdata[4:0];
            CSR_IDX_TARGET:    tgt_in = pwdata[SMP_W-1:0];
            CSR_IDX_THRESHOLD: thr_in = pwdata[SMP_W-2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_IDX_CHANNELS:  prdata = {27'd0, ch_ff};
         CSR_IDX_TARGET:    prdata = {8'd0, tgt_ff};
         CSR_IDX_THRESHOLD: prdata = {9'd0, thr_ff};
         default:           prdata = '0;
      endcase
   end

   // shared units
   assign div_dividend = div_gain ? {tgt_ff, {FRAC_W{1'b0}}} : GAIN_W'(count_ff);
   assign div_divisor  = div_gain ? peak_ff :
                         ((ch_ff == 5'd0) ? SMP_W'(1) : SMP_W'(ch_ff));

   pn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   pn_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (scl_start),
      .sample (rd_ff),
      .gain   (gain_ff),
      .result (scl_res)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign room     = (count_ff < CNT_W'(MAX_SAMPLES));
   assign mag      = req_data.sample_in[SMP_W-1] ? SMP_W'(-req_data.sample_in)
                                                 : SMP_W'(req_data.sample_in);
   assign last_idx = (idx_ff == IDX_W'(count_ff - CNT_W'(1)));
   assign silent   = (peak_ff < {1'b0, thr_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && req_data.last_in) state_in = ST_CHECK;
         ST_CHECK:  state_in = ovf_ff ? ST_FAULT : ST_MOD;
         ST_MOD:    if (div_res.done) state_in = ST_DECIDE;
         ST_DECIDE: begin
            priority if (div_res.remainder != '0) state_in = ST_FAULT;
            else if (silent)                      state_in = ST_READ;
            else if (peak_ff == '0)               state_in = ST_FAULT;
            else                                  state_in = ST_DIV;
         end
         ST_DIV:    if (div_res.done) state_in = ST_READ;
         ST_READ:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_SCALE;
         ST_SCALE: begin
            if (scl_res.done) begin
               priority if (!emit_ff && scl_res.out_of_range) state_in = ST_FAULT;
               else if (emit_ff && last_idx)                  state_in = ST_IDLE;
               else                                           state_in = ST_READ;
            end
         end
         ST_FAULT:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      div_start  = 1'b0;
      div_gain   = 1'b0;
      scl_start  = 1'b0;
      start_pass = 1'b0;
      load_gain  = 1'b0;
      scan_end   = 1'b0;
      step_idx   = 1'b0;
      emit_now   = 1'b0;
      fault_now  = 1'b0;
      set_fault  = 1'b0;
      fault_code = STATUS_OK;
      unique case (state_ff)
         ST_CHECK: begin
            if (ovf_ff) begin
               set_fault  = 1'b1;
               fault_code = STATUS_OVERFLOW;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_DECIDE: begin
            div_gain = 1'b1;
            priority if (div_res.remainder != '0) begin
               set_fault  = 1'b1;
               fault_code = STATUS_MISALIGNED;
            end else if (silent) begin
               start_pass = 1'b1;
            end else if (peak_ff == '0) begin
               set_fault  = 1'b1;
               fault_code = STATUS_ZERO_GAIN;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_DIV:    load_gain = div_res.done;
         ST_LAUNCH: scl_start = 1'b1;
         ST_SCALE: begin
            if (scl_res.done) begin
               if (emit_ff) begin
                  emit_now = 1'b1;
                  step_idx = !last_idx;
               end else if (scl_res.out_of_range) begin
                  set_fault  = 1'b1;
                  fault_code = STATUS_RANGE;
               end else begin
                  scan_end = last_idx;
                  step_idx = !last_idx;
               end
            end
         end
         ST_FAULT:  fault_now = 1'b1;
         default: ;
      endcase
   end

   assign clear = fault_now || (emit_now && last_idx);

   // buffer and sequencing state
   always_comb begin
      count_in = count_ff;
      peak_in  = peak_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      emit_in  = emit_ff;
      pass_in  = pass_ff;
      gain_in  = gain_ff;
      fault_in = set_fault ? fault_code : fault_ff;
      if (accept) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
            if (mag > peak_ff) peak_in = mag;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (start_pass) begin
         pass_in = 1'b1;
         gain_in = GAIN_ONE;
         emit_in = 1'b1;
         idx_in  = '0;
      end
      if (load_gain) begin
         pass_in = 1'b0;
         gain_in = div_res.quotient;
         emit_in = 1'b0;
         idx_in  = '0;
      end
      if (scan_end) begin
         emit_in = 1'b1;
         idx_in  = '0;
      end
      if (step_idx) idx_in = idx_ff + IDX_W'(1);
      if (clear) begin
         count_in = '0;
         peak_in  = '0;
         ovf_in   = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_strobe_in            = emit_now || fault_now;
      rsp_data_in.sample_out   = emit_now ? scl_res.value : '0;
      rsp_data_in.status       = emit_now ? STATUS_OK : fault_ff;
      rsp_data_in.passthrough  = emit_now && pass_ff;
      rsp_data_in.peak_level   = (emit_now || fault_ff == STATUS_RANGE ||
                                  fault_ff == STATUS_ZERO_GAIN) ? peak_ff : '0;
      rsp_data_in.applied_gain = emit_now ? gain_ff : GAIN_ONE;
      rsp_data_in.last_out     = fault_now || last_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ch_ff         <= 5'd2;
         tgt_ff        <= SMP_W'(1) << (SMP_W - 1);
         thr_ff        <= '0;
         count_ff      <= '0;
         peak_ff       <= '0;
         ovf_ff        <= 1'b0;
         emit_ff       <= 1'b0;
         pass_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         tgt_ff        <= tgt_in;
         thr_ff        <= thr_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         ovf_ff        <= ovf_in;
         emit_ff       <= emit_in;
         pass_ff       <= pass_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff      <= idx_in;
      gain_ff     <= gain_in;
      fault_ff    <= fault_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (accept && room) sample_store[count_ff[IDX_W-1:0]] <= req_data.sample_in;
      rd_ff <= sample_store[idx_ff];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `PN_ASSERT(a_rsp_from_busy, clock, reset, rsp_strobe_ff |-> $past(state_ff != ST_IDLE), "result while idle")
   `PN_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(MAX_SAMPLES), "count past buffer")
   `PN_ASSERT(a_error_shape, clock, reset, (rsp_strobe_ff && rsp_data_ff.status != STATUS_OK) |-> (rsp_data_ff.sample_out == '0 && rsp_data_ff.last_out), "bad error result")
   `PN_ASSERT(a_last_clears, clock, reset, (rsp_strobe_ff && rsp_data_ff.last_out) |-> (count_ff == '0 && !busy), "buffer not cleared")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak normalizer testbench
// Streams buffers of Q1.23 samples through the command port and reprograms
// channel count, target peak and silence threshold between phases. Every
// output transfer is checked field by field against a behavioral model of
// the normalizer that runs on each accepted sample, or against a result pinned in the stimulus.
// ----------------------------------------------------------------------------
module testbench;
   import pn_pkg::*;

   typedef enum logic [1:0] {
      ROW_DATA,
      ROW_PINNED,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic signed [SMP_W-1:0] smp;
      logic                    lst;
      int                      reps;
      logic [1:0]              csr;
      logic [31:0]             value;
      logic [2:0]              status;
      logic [SMP_W-1:0]        peak;
   } stim_row_type;

   localparam int SETTLE_CYCLES = 64;
   localparam int DRAIN_CYCLES  = 1000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   pn_req_type  req_data;
   logic        rsp_strobe;
   pn_rsp_type  rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [4:0]              cfg_channels;
   logic [23:0]             cfg_target;
   logic [22:0]             cfg_threshold;
   logic signed [SMP_W-1:0] held_samples [MAX_SAMPLES];
   logic [SMP_W-1:0]        peak_seen;
   int                      held_count;
   logic                    dropped;

   pn_rsp_type   buffer_outputs[$];
   pn_rsp_type   outputs_due[$];
   stim_row_type stim_rows[$];
   int           error_count;

   peak_normalizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic pn_rsp_type make_rsp(input logic signed [SMP_W-1:0] smp,
                                           input logic [2:0] status,
                                           input logic pass,
                                           input logic [SMP_W-1:0] peak,
                                           input logic [GAIN_W-1:0] gain,
                                           input logic lst);
      pn_rsp_type r;
      r.sample_out   = smp;
      r.status       = status;
      r.passthrough  = pass;
      r.peak_level   = peak;
      r.applied_gain = gain;
      r.last_out     = lst;
      return r;
   endfunction

   function automatic void clear_buffer();
      peak_seen  = '0;
      held_count = 0;
      dropped    = 1'b0;
   endfunction

   function automatic void normalize_step(input logic signed [SMP_W-1:0] smp,
                                          input logic lst);
      int                      mag;
      int                      channels;
      logic [GAIN_W-1:0]       gain;
      longint                  prod;
      longint                  scaled;
      logic signed [SMP_W-1:0] outs [MAX_SAMPLES];
      logic                    bad;
      buffer_outputs.delete();
      mag = (smp < 0) ? -int'(smp) : int'(smp);
      if (held_count < MAX_SAMPLES) begin
         held_samples[held_count] = smp;
         held_count++;
         if (mag > int'(peak_seen)) peak_seen = mag;
      end else begin
         dropped = 1'b1;
      end
      if (!lst) return;
      channels = (cfg_channels == 0) ? 1 : int'(cfg_channels);
      if (dropped) begin
         buffer_outputs.push_back(make_rsp('0, STATUS_OVERFLOW, 1'b0, '0, GAIN_ONE, 1'b1));
      end else if (held_count % channels != 0) begin
         buffer_outputs.push_back(make_rsp('0, STATUS_MISALIGNED, 1'b0, '0, GAIN_ONE, 1'b1));
      end else if (peak_seen < cfg_threshold) begin
         for (int i = 0; i < held_count; i++)
            buffer_outputs.push_back(make_rsp(held_samples[i], STATUS_OK, 1'b1, peak_seen,
                                              GAIN_ONE, i == held_count - 1));
      end else if (peak_seen == 0) begin
         buffer_outputs.push_back(make_rsp('0, STATUS_ZERO_GAIN, 1'b0, '0, GAIN_ONE, 1'b1));
      end else begin
         gain = {cfg_target, 24'b0} / {24'b0, peak_seen};
         bad  = 1'b0;
         for (int i = 0; i < held_count && !bad; i++) begin
            prod   = longint'(held_samples[i]) * longint'({16'b0, gain});
            scaled = (prod + 64'sd8388608) >>> 24;
            if (scaled > 64'sd8388607 || scaled < -64'sd8388608) bad = 1'b1;
            else outs[i] = scaled[SMP_W-1:0];
         end
         if (bad) begin
            buffer_outputs.push_back(make_rsp('0, STATUS_RANGE, 1'b0, peak_seen,
                                              GAIN_ONE, 1'b1));
         end else begin
            for (int i = 0; i < held_count; i++)
               buffer_outputs.push_back(make_rsp(outs[i], STATUS_OK, 1'b0, peak_seen, gain,
                                                 i == held_count - 1));
         end
      end
      clear_buffer();
   endfunction

   function automatic logic [31:0] csr_value(input logic [1:0] idx);
      case (idx)
         CSR_IDX_CHANNELS: return 32'(cfg_channels);
         CSR_IDX_TARGET:   return 32'(cfg_target);
         default:          return 32'(cfg_threshold);
      endcase
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void add_data(input logic signed [SMP_W-1:0] smp, input logic lst,
                                    input int reps);
      stim_row_type row;
      row.kind = ROW_DATA;
      row.smp  = smp;
      row.lst  = lst;
      row.reps = reps;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_pinned(input logic signed [SMP_W-1:0] smp,
                                      input logic [2:0] status, input logic [SMP_W-1:0] peak);
      stim_row_type row;
      row.kind   = ROW_PINNED;
      row.smp    = smp;
      row.lst    = 1'b1;
      row.reps   = 1;
      row.status = status;
      row.peak   = peak;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [1:0] csr, input logic [31:0] value);
      stim_row_type row;
      row.kind  = ROW_WRITE;
      row.csr   = csr;
      row.value = value;
      stim_rows.push_back(row);
   endfunction

   task automatic send_sample(input logic signed [SMP_W-1:0] smp, input logic lst,
                              input int gap, input bit pinned, input pn_rsp_type typed);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_data.sample_in <= smp;
      req_data.last_in   <= lst;
      do @(posedge clock); while (busy);
      normalize_step(smp, lst);
      if (pinned) begin
         if (lst) outputs_due.push_back(typed);
      end else begin
         foreach (buffer_outputs[i]) outputs_due.push_back(buffer_outputs[i]);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outputs_due.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read(input logic [1:0] idx);
      logic [31:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== csr_value(idx)) begin
         $error("register %0d expected %0d got %0d", idx, csr_value(idx), got);
         error_count++;
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         CSR_IDX_CHANNELS: cfg_channels  = value[4:0];
         CSR_IDX_TARGET:   cfg_target    = value[23:0];
         default:          cfg_threshold = value[22:0];
      endcase
      csr_read(idx);
   endtask

   always @(posedge clock) begin
      pn_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outputs_due.size() == 0) begin
            $error("output transfer with nothing expected, sample_out %0d status %0d",
                   rsp_data.sample_out, rsp_data.status);
            error_count++;
         end else begin
            want = outputs_due.pop_front();
            check_field("sample_out", longint'(want.sample_out),
                        longint'(rsp_data.sample_out));
            check_field("status", longint'(want.status), longint'(rsp_data.status));
            check_field("passthrough", longint'(want.passthrough),
                        longint'(rsp_data.passthrough));
            check_field("peak_level", longint'(want.peak_level),
                        longint'(rsp_data.peak_level));
            check_field("applied_gain", longint'(want.applied_gain),
                        longint'(rsp_data.applied_gain));
            check_field("last_out", longint'(want.last_out), longint'(rsp_data.last_out));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                      phase_items;
      int                      len;
      int                      ch_eff;
      int                      max_frames;
      int                      pick;
      int                      shift;
      int                      overflow_buffers;
      int                      wait_cycles;
      bit                      silent;
      bit                      steady;
      logic signed [SMP_W-1:0] smp;
      logic [31:0]             ch_value;
      logic [31:0]             target_value;
      logic [31:0]             threshold_value;

      error_count      = 0;
      overflow_buffers = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      cfg_channels  = 5'd2;
      cfg_target    = 24'd8388608;
      cfg_threshold = '0;
      clear_buffer();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      csr_read(CSR_IDX_CHANNELS);
      csr_read(CSR_IDX_TARGET);
      csr_read(CSR_IDX_THRESHOLD);

      // zero peak, odd count, full-scale extremes, +1.0 out of range, -1.0 reached, overflow
      add_data(24'sd0, 1'b0, 1);
      add_pinned(24'sd0, STATUS_ZERO_GAIN, 24'd0);
      add_pinned(24'sd5, STATUS_MISALIGNED, 24'd0);
      add_data(24'sh7FFFFF, 1'b0, 1);
      add_data(24'sh800000, 1'b1, 1);
      add_data(24'sd4194304, 1'b0, 1);
      add_pinned(24'sd1, STATUS_RANGE, 24'd4194304);
      add_data(-24'sd4194304, 1'b0, 1);
      add_data(24'sd1, 1'b1, 1);
      add_data(24'sd100, 1'b0, 65);
      add_pinned(24'sd7, STATUS_OVERFLOW, 24'd0);
      add_data(24'sd3, 1'b0, 63);
      add_data(-24'sd3, 1'b1, 1);
      // silence ahead of zero gain, zero channel count
      add_write(CSR_IDX_THRESHOLD, 32'd100);
      add_data(24'sd0, 1'b0, 1);
      add_data(24'sd0, 1'b1, 1);
      add_write(CSR_IDX_CHANNELS, 32'd0);
      add_data(24'sd3, 1'b1, 1);
      // target zero and above 1.0
      add_write(CSR_IDX_CHANNELS, 32'd1);
      add_write(CSR_IDX_TARGET, 32'd0);
      add_write(CSR_IDX_THRESHOLD, 32'd0);
      add_data(24'sd5, 1'b0, 1);
      add_data(-24'sd9, 1'b1, 1);
      add_write(CSR_IDX_TARGET, 32'hFFFFFF);
      add_data(24'sd10, 1'b0, 1);
      add_data(-24'sd1000, 1'b1, 1);
      add_write(CSR_IDX_TARGET, 32'd1);
      add_data(24'sh7FFFFF, 1'b1, 1);
      add_write(CSR_IDX_TARGET, 32'd8388608);
      add_write(CSR_IDX_THRESHOLD, 32'd8388607);
      add_data(24'sd8388606, 1'b0, 1);
      add_data(-24'sd2, 1'b1, 1);
      add_data(24'sh800000, 1'b1, 1);

      foreach (stim_rows[k]) begin
         case (stim_rows[k].kind)
            ROW_WRITE: begin
               settle();
               csr_write(stim_rows[k].csr, stim_rows[k].value);
            end
            ROW_PINNED: begin
               send_sample(stim_rows[k].smp, stim_rows[k].lst, $urandom_range(0, 9), 1'b1,
                           make_rsp('0, stim_rows[k].status, 1'b0, stim_rows[k].peak,
                                    GAIN_ONE, 1'b1));
            end
            default: begin
               repeat (stim_rows[k].reps)
                  send_sample(stim_rows[k].smp, stim_rows[k].lst, $urandom_range(0, 9),
                              1'b0, '0);
            end
         endcase
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               ch_value = 1; target_value = 8388608; threshold_value = 0;
            end
            1: begin
               ch_value = 16; target_value = 1; threshold_value = 8388607;
            end
            3: begin
               ch_value = 31; target_value = 24'hFFFFFF; threshold_value = 0;
            end
            4: begin
               ch_value = 0; target_value = 0;
               threshold_value = $urandom_range(0, 8388607) >> $urandom_range(0, 23);
            end
            default: begin
               ch_value        = $urandom_range(1, 16);
               target_value    = $urandom_range(1, 8388608);
               threshold_value = $urandom_range(0, 8388607) >> $urandom_range(0, 23);
            end
         endcase
         settle();
         csr_write(CSR_IDX_CHANNELS, ch_value);
         csr_write(CSR_IDX_TARGET, target_value);
         csr_write(CSR_IDX_THRESHOLD, threshold_value);

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            ch_eff     = (cfg_channels == 0) ? 1 : int'(cfg_channels);
            max_frames = MAX_SAMPLES / ch_eff;
            pick       = $urandom_range(0, 99);
            if (pick < 4 && overflow_buffers < 2) begin
               len = $urandom_range(65, 68);
               overflow_buffers++;
            end else if (pick < 20) begin
               len = $urandom_range(1, 20);
            end else if (pick < 30) begin
               len = ch_eff * $urandom_range(1, max_frames);
            end else begin
               len = ch_eff * $urandom_range(1, (max_frames < 3) ? max_frames : 3);
            end
            shift  = $urandom_range(0, 23);
            silent = ($urandom_range(0, 19) == 0);
            steady = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < len; n++) begin
               if (silent) smp = '0;
               else if ($urandom_range(0, 19) == 0)
                  smp = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
               else smp = $signed(24'($urandom)) >>> shift;
               send_sample(smp, n == len - 1, steady ? 0 : $urandom_range(0, 9), 1'b0, '0);
               if (n < MAX_SAMPLES) phase_items++;
            end
         end
      end

      start <= 1'b0;
      wait_cycles = 0;
      while (outputs_due.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outputs_due.size() != 0) begin
         $error("%0d expected output transfers never arrived", outputs_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
